// File: design/ray_line_distance_core_macros.svh
// assertion helpers, sampled on i_clk and held off while i_rst_n is low
`ifndef RAY_LINE_DISTANCE_CORE_MACROS_SVH
`define RAY_LINE_DISTANCE_CORE_MACROS_SVH

// consequence in the same cycle
`define RLD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence in the next cycle
`define RLD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/rld_pkg.sv
`timescale 1ns / 1ps
package rld_pkg;

    localparam int FRAC_BITS_DEF = 16;
    // register stages of one saturating multiply
    localparam int MUL_LAT = 4;
    localparam int SQRT_LAT = 32;

    typedef logic signed [63:0] t_s64;

    localparam t_s64 SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_END_X    = 3'd3,
        CFG_END_Y    = 3'd4,
        CFG_END_Z    = 3'd5,
        CFG_THRESH   = 3'd6
    } t_cfg_idx;

    // symmetric saturating add
    function automatic t_s64 sadd(input t_s64 a, input t_s64 b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(SMAX)) begin
            return SMAX;
        end
        if (s < -65'(SMAX)) begin
            return -SMAX;
        end
        return t_s64'(s[63:0]);
    endfunction

endpackage

// File: design/rld_line_if.sv
`timescale 1ns / 1ps
interface rld_line_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] line_start_x;
    logic signed [31:0] line_start_y;
    logic signed [31:0] line_start_z;
    logic signed [31:0] line_finish_x;
    logic signed [31:0] line_finish_y;
    logic signed [31:0] line_finish_z;

    modport source (
        output valid, line_start_x, line_start_y, line_start_z,
               line_finish_x, line_finish_y, line_finish_z,
        input  ready
    );
    modport sink (
        input  valid, line_start_x, line_start_y, line_start_z,
               line_finish_x, line_finish_y, line_finish_z,
        output ready
    );
endinterface

// File: design/rld_result_if.sv
`timescale 1ns / 1ps
interface rld_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] distance;
    logic        near_parallel;

    modport source (
        output valid, distance, near_parallel,
        input  ready
    );
    modport sink (
        input  valid, distance, near_parallel,
        output ready
    );
endinterface

// File: design/rld_delay.sv
`timescale 1ns / 1ps
module rld_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_ce,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_line [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_line[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_line[i] <= r_line[i-1];
            end
        end
    end

    assign o_q = r_line[DEPTH-1];

endmodule

// File: design/rld_mul.sv
`timescale 1ns / 1ps
module rld_mul #(
    parameter int FRAC_BITS = rld_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_ce,
    input  rld_pkg::t_s64 i_a,
    input  rld_pkg::t_s64 i_b,
    output rld_pkg::t_s64 o_p
);

    logic [63:0]   r_am, r_bm;
    logic          r_neg1, r_neg2, r_neg3;
    logic [63:0]   r_p00, r_p01, r_p10, r_p11;
    logic [127:0]  r_prod;
    rld_pkg::t_s64 r_p;
    logic [127:0]  n_prod;
    logic [127:0]  n_sh;
    logic [63:0]   n_mag;

    always_comb begin
        n_prod = {64'b0, r_p00} + {32'b0, r_p01, 32'b0} + {32'b0, r_p10, 32'b0}
               + {r_p11, 64'b0};
        n_sh   = r_prod >> FRAC_BITS;
        n_mag  = (n_sh[127:63] != '0) ? 64'(rld_pkg::SMAX) : n_sh[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_am   <= i_a[63] ? 64'(-i_a) : 64'(i_a);
            r_bm   <= i_b[63] ? 64'(-i_b) : 64'(i_b);
            r_neg1 <= i_a[63] ^ i_b[63];
            // four 32x32 partial products
            r_p00  <= 64'(r_am[31:0])  * 64'(r_bm[31:0]);
            r_p01  <= 64'(r_am[31:0])  * 64'(r_bm[63:32]);
            r_p10  <= 64'(r_am[63:32]) * 64'(r_bm[31:0]);
            r_p11  <= 64'(r_am[63:32]) * 64'(r_bm[63:32]);
            r_neg2 <= r_neg1;
            r_prod <= n_prod;
            r_neg3 <= r_neg2;
            r_p    <= r_neg3 ? -rld_pkg::t_s64'(n_mag) : rld_pkg::t_s64'(n_mag);
        end
    end

    assign o_p = r_p;

endmodule

// File: design/rld_div.sv
`timescale 1ns / 1ps
module rld_div #(
    parameter int FRAC_BITS = rld_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_ce,
    input  rld_pkg::t_s64 i_num,
    input  rld_pkg::t_s64 i_den,
    output rld_pkg::t_s64 o_q
);

    localparam int NB = 64 + FRAC_BITS;

    logic [63:0]   r_rem [NB+1];
    logic [63:0]   r_q   [NB+1];
    logic [63:0]   r_nn  [NB+1];
    logic [63:0]   r_dd  [NB+1];
    logic          r_sat [NB+1];
    logic          r_ng  [NB+1];
    logic          r_zr  [NB+1];
    rld_pkg::t_s64 r_out;
    logic [63:0]   n_mag;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0] <= '0;
            r_q[0]   <= '0;
            r_sat[0] <= 1'b0;
            r_nn[0]  <= i_num[63] ? 64'(-i_num) : 64'(i_num);
            r_dd[0]  <= i_den[63] ? 64'(-i_den) : 64'(i_den);
            r_ng[0]  <= i_num[63] ^ i_den[63];
            r_zr[0]  <= (i_den == '0);
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < NB; k++) begin : g_step
        localparam int P = NB - 1 - k;
        logic        n_bit;
        logic [63:0] n_r;
        logic        n_ge;

        if (P >= FRAC_BITS) begin : g_nbit
            assign n_bit = r_nn[k][P-FRAC_BITS];
        end else begin : g_zbit
            assign n_bit = 1'b0;
        end

        always_comb begin
            n_r  = {r_rem[k][62:0], n_bit};
            n_ge = (n_r >= r_dd[k]);
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k+1] <= n_ge ? n_r - r_dd[k] : n_r;
                r_q[k+1]   <= {r_q[k][62:0], n_ge};
                // a set bit at weight 2^63 or above overflows
                r_sat[k+1] <= r_sat[k] | (n_ge && (P >= 63));
                r_nn[k+1]  <= r_nn[k];
                r_dd[k+1]  <= r_dd[k];
                r_ng[k+1]  <= r_ng[k];
                r_zr[k+1]  <= r_zr[k];
            end
        end
    end

    always_comb begin
        if (r_zr[NB]) begin
            n_mag = '0;
        end else if (r_sat[NB]) begin
            n_mag = 64'(rld_pkg::SMAX);
        end else begin
            n_mag = r_q[NB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_out <= r_ng[NB] ? -rld_pkg::t_s64'(n_mag) : rld_pkg::t_s64'(n_mag);
        end
    end

    assign o_q = r_out;

endmodule

// File: design/rld_sqrt.sv
`timescale 1ns / 1ps
module rld_sqrt (
    input  logic        i_clk,
    input  logic        i_ce,
    input  logic [63:0] i_x,
    input  logic        i_sat,
    output logic [31:0] o_root
);

    localparam int NS = rld_pkg::SQRT_LAT;

    logic [63:0] r_x   [NS];
    logic [63:0] r_res [NS];
    logic        r_sat [NS];

    for (genvar k = 0; k < NS; k++) begin : g_step
        localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
        logic [63:0] g_x, g_res, n_sum;
        logic        g_sat;

        if (k == 0) begin : g_first
            assign g_x   = i_x;
            assign g_res = '0;
            assign g_sat = i_sat;
        end else begin : g_next
            assign g_x   = r_x[k-1];
            assign g_res = r_res[k-1];
            assign g_sat = r_sat[k-1];
        end

        assign n_sum = g_res + BIT;

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                if (g_x >= n_sum) begin
                    r_x[k]   <= g_x - n_sum;
                    r_res[k] <= (g_res >> 1) + BIT;
                end else begin
                    r_x[k]   <= g_x;
                    r_res[k] <= g_res >> 1;
                end
                r_sat[k] <= g_sat;
            end
        end
    end

    assign o_root = r_sat[NS-1] ? '1 : r_res[NS-1][31:0];

endmodule

// File: design/ray_line_distance_core.sv
`timescale 1ns / 1ps
// shortest distance between the configured ray line and a line through two points
// i_line: one line per transfer (start and finish points, signed fixed point)
// o_result: one distance (unsigned fixed point, saturated) and near-parallel flag
// per input transfer, in input order
// config port: i_cfg_we / i_cfg_idx / i_cfg_data, write only while no line is in flight
// the pipeline is mostly the bit-serial divider pipeline (64 + FRAC_BITS stages) and the
// 32-stage square root pipeline, plus four-stage 64-bit multipliers
// throughput: one line per cycle, taken every cycle unless a held result stalls
// reset: synchronous, clears all in-flight valids and loads the register defaults
// when the receiver stalls a held result, the whole pipeline freezes and i_line.ready
// drops; nothing is lost or repeated, and the stage buffers resume on release
`include "ray_line_distance_core_macros.svh"
module ray_line_distance_core #(
    parameter int FRAC_BITS = rld_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rld_line_if.sink     i_line,
    rld_result_if.source o_result,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);

    localparam int ML      = rld_pkg::MUL_LAT;
    localparam int DIV_LAT = 64 + FRAC_BITS + 2;
    localparam int S_DOT   = 2 + ML;
    localparam int S_DET   = S_DOT + ML + 1;
    localparam int S_DIV   = S_DET + DIV_LAT;
    localparam int LAT     = S_DIV + 2 * ML + 3 + rld_pkg::SQRT_LAT;

    logic signed [31:0] r_org [3];
    logic signed [31:0] r_end [3];
    logic [31:0]        r_thr;

    logic               ce, accept;
    logic [LAT-1:0]     r_vld;

    logic signed [32:0] r_v [3];
    logic signed [32:0] r_w [3];

    rld_pkg::t_s64 s_u [3], s_v [3], s_w [3];
    rld_pkg::t_s64 d1_x [5][3], d1_y [5][3], d1_p [5][3];
    rld_pkg::t_s64 r_dot [5];
    rld_pkg::t_s64 m2_x [6], m2_y [6], m2_p [6];
    rld_pkg::t_s64 r_det, r_ns, r_nt;
    logic [319:0]  dd_q;
    rld_pkg::t_s64 dd [5];
    logic          par, bgc, par_out;
    rld_pkg::t_s64 sc_num, tc_num, tc_den, sc, tc;
    logic [98:0]   vd_q, wd_q;
    rld_pkg::t_s64 vd [3], wd [3];
    rld_pkg::t_s64 pu [3], pv [3];
    rld_pkg::t_s64 r_dp [3];
    rld_pkg::t_s64 pd [3];
    rld_pkg::t_s64 r_dt;
    rld_pkg::t_s64 dtc;
    logic [63:0]   r_sqx;
    logic          r_sqsat;
    logic [31:0]   root;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_end[0] <= '0;
            r_end[1] <= '0;
            r_end[2] <= 32'sd65536;
            r_thr    <= 32'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rld_pkg::CFG_ORIGIN_X: r_org[0] <= i_cfg_data;
                rld_pkg::CFG_ORIGIN_Y: r_org[1] <= i_cfg_data;
                rld_pkg::CFG_ORIGIN_Z: r_org[2] <= i_cfg_data;
                rld_pkg::CFG_END_X:    r_end[0] <= i_cfg_data;
                rld_pkg::CFG_END_Y:    r_end[1] <= i_cfg_data;
                rld_pkg::CFG_END_Z:    r_end[2] <= i_cfg_data;
                rld_pkg::CFG_THRESH:   r_thr    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: move whenever the output slot is free or being drained
    assign ce             = !r_vld[LAT-1] || o_result.ready;
    assign i_line.ready   = ce;
    assign accept         = i_line.valid && ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end

    // direction and offset vectors
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_v[0] <= 33'(i_line.line_finish_x) - 33'(i_line.line_start_x);
            r_v[1] <= 33'(i_line.line_finish_y) - 33'(i_line.line_start_y);
            r_v[2] <= 33'(i_line.line_finish_z) - 33'(i_line.line_start_z);
            r_w[0] <= 33'(r_org[0]) - 33'(i_line.line_start_x);
            r_w[1] <= 33'(r_org[1]) - 33'(i_line.line_start_y);
            r_w[2] <= 33'(r_org[2]) - 33'(i_line.line_start_z);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s_u[i] = rld_pkg::t_s64'(r_end[i]) - rld_pkg::t_s64'(r_org[i]);
            s_v[i] = rld_pkg::t_s64'(r_v[i]);
            s_w[i] = rld_pkg::t_s64'(r_w[i]);
            d1_x[0][i] = s_u[i];  d1_y[0][i] = s_u[i];
            d1_x[1][i] = s_u[i];  d1_y[1][i] = s_v[i];
            d1_x[2][i] = s_v[i];  d1_y[2][i] = s_v[i];
            d1_x[3][i] = s_u[i];  d1_y[3][i] = s_w[i];
            d1_x[4][i] = s_v[i];  d1_y[4][i] = s_w[i];
        end
    end

    // a, b, c, d, e
    for (genvar j = 0; j < 5; j++) begin : g_dot
        for (genvar i = 0; i < 3; i++) begin : g_term
            rld_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
                .i_clk(i_clk), .i_ce(ce), .i_a(d1_x[j][i]), .i_b(d1_y[j][i]),
                .o_p(d1_p[j][i])
            );
        end
        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_dot[j] <= rld_pkg::sadd(rld_pkg::sadd(d1_p[j][0], d1_p[j][1]),
                                          d1_p[j][2]);
            end
        end
    end

    // ac, bb, be, cd, ae, bd
    always_comb begin
        m2_x[0] = r_dot[0];  m2_y[0] = r_dot[2];
        m2_x[1] = r_dot[1];  m2_y[1] = r_dot[1];
        m2_x[2] = r_dot[1];  m2_y[2] = r_dot[4];
        m2_x[3] = r_dot[2];  m2_y[3] = r_dot[3];
        m2_x[4] = r_dot[0];  m2_y[4] = r_dot[4];
        m2_x[5] = r_dot[1];  m2_y[5] = r_dot[3];
    end

    for (genvar j = 0; j < 6; j++) begin : g_cross
        rld_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
            .i_clk(i_clk), .i_ce(ce), .i_a(m2_x[j]), .i_b(m2_y[j]), .o_p(m2_p[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_det <= rld_pkg::sadd(m2_p[0], -m2_p[1]);
            r_ns  <= rld_pkg::sadd(m2_p[2], -m2_p[3]);
            r_nt  <= rld_pkg::sadd(m2_p[4], -m2_p[5]);
        end
    end

    rld_delay #(.WIDTH(320), .DEPTH(ML + 1)) u_dly_dot (
        .i_clk(i_clk), .i_ce(ce),
        .i_d({r_dot[0], r_dot[1], r_dot[2], r_dot[3], r_dot[4]}), .o_q(dd_q)
    );

    always_comb begin
        for (int j = 0; j < 5; j++) begin
            dd[j] = rld_pkg::t_s64'(dd_q[64*(4-j) +: 64]);
        end
        par = r_det < rld_pkg::t_s64'(r_thr);
        bgc = dd[1] > dd[2];
        // near-parallel: sc is zero, tc from the larger of b and c
        if (par) begin
            sc_num = '0;
            tc_num = bgc ? dd[3] : dd[4];
            tc_den = bgc ? dd[1] : dd[2];
        end else begin
            sc_num = r_ns;
            tc_num = r_nt;
            tc_den = r_det;
        end
    end

    rld_div #(.FRAC_BITS(FRAC_BITS)) u_div_sc (
        .i_clk(i_clk), .i_ce(ce), .i_num(sc_num), .i_den(r_det), .o_q(sc)
    );

    rld_div #(.FRAC_BITS(FRAC_BITS)) u_div_tc (
        .i_clk(i_clk), .i_ce(ce), .i_num(tc_num), .i_den(tc_den), .o_q(tc)
    );

    rld_delay #(.WIDTH(1), .DEPTH(LAT - S_DET)) u_dly_par (
        .i_clk(i_clk), .i_ce(ce), .i_d(par), .o_q(par_out)
    );

    rld_delay #(.WIDTH(99), .DEPTH(S_DIV - 1)) u_dly_v (
        .i_clk(i_clk), .i_ce(ce), .i_d({r_v[0], r_v[1], r_v[2]}), .o_q(vd_q)
    );

    rld_delay #(.WIDTH(99), .DEPTH(S_DIV + ML - 1)) u_dly_w (
        .i_clk(i_clk), .i_ce(ce), .i_d({r_w[0], r_w[1], r_w[2]}), .o_q(wd_q)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vd[i] = rld_pkg::t_s64'($signed(vd_q[33*(2-i) +: 33]));
            wd[i] = rld_pkg::t_s64'($signed(wd_q[33*(2-i) +: 33]));
        end
    end

    // closest-point difference vector
    for (genvar i = 0; i < 3; i++) begin : g_dp
        rld_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_u (
            .i_clk(i_clk), .i_ce(ce), .i_a(sc), .i_b(s_u[i]), .o_p(pu[i])
        );
        rld_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_v (
            .i_clk(i_clk), .i_ce(ce), .i_a(tc), .i_b(vd[i]), .o_p(pv[i])
        );
        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_dp[i] <= rld_pkg::sadd(rld_pkg::sadd(wd[i], pu[i]), -pv[i]);
            end
        end
        rld_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_sq (
            .i_clk(i_clk), .i_ce(ce), .i_a(r_dp[i]), .i_b(r_dp[i]), .o_p(pd[i])
        );
    end

    assign dtc = r_dt[63] ? '0 : r_dt;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_dt    <= rld_pkg::sadd(rld_pkg::sadd(pd[0], pd[1]), pd[2]);
            r_sqsat <= ((64'(dtc) >> (64 - FRAC_BITS)) != '0);
            r_sqx   <= 64'(dtc) << FRAC_BITS;
        end
    end

    rld_sqrt u_sqrt (
        .i_clk(i_clk), .i_ce(ce), .i_x(r_sqx), .i_sat(r_sqsat), .o_root(root)
    );

    assign o_result.valid         = r_vld[LAT-1];
    assign o_result.distance      = root;
    assign o_result.near_parallel = par_out;

    `RLD_ASSERT_NEXT(a_accept_enters, accept, r_vld[0], "accepted line not in first stage")
    `RLD_ASSERT_NEXT(a_stall_holds, !ce, $stable(r_vld), "pipeline moved during stall")
    `RLD_ASSERT_SAME(a_stall_blocks_in, o_result.valid && !o_result.ready, !i_line.ready,
                     "input taken while result stalled")
    `RLD_ASSERT_NEXT(a_drain_empties,
                     o_result.valid && o_result.ready && !r_vld[LAT-2],
                     !o_result.valid, "result repeated after transfer")

endmodule
